// ----- design/otc_pkg.sv -----
// Package for the optical torque calibrator: widths, register indexes, enums.
// No dependencies; imported by every design module.
package otc_pkg;

  localparam int unsigned Channels   = 8;
  localparam int unsigned ChBits     = 3;
  localparam int unsigned CountBits  = 12;
  localparam int unsigned SumBits    = 28;
  localparam int unsigned DivBits    = 28;  // dividend magnitude width
  localparam int unsigned DvsBits    = 17;  // divisor magnitude width
  localparam int unsigned EntryBits  = 16 + SumBits;
  localparam int unsigned AddrBits   = 6;

  typedef enum logic [2:0] {
    REG_C1_LO   = 3'd0,
    REG_C1_HI   = 3'd1,
    REG_C2_LO   = 3'd2,
    REG_C2_HI   = 3'd3,
    REG_WARMUP  = 3'd4,
    REG_AVERAGE = 3'd5
  } reg_idx_e;

  typedef enum logic [1:0] {
    PH_WARMUP  = 2'd0,
    PH_AVERAGE = 2'd1,
    PH_RUN     = 2'd2
  } phase_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_START,
    ST_WAIT,
    ST_WRITE,
    ST_OFS_READ,
    ST_OFS_START,
    ST_OFS_WAIT,
    ST_OFS_WRITE,
    ST_EMIT
  } state_e;

  // memory entry: offset above running sum
  typedef struct packed {
    logic signed [15:0]        offset;
    logic signed [SumBits-1:0] sum;
  } entry_t;

endpackage

// ----- design/optical_torque_calibrator_top.sv -----
// Channel  | handshake            | payload
// input    | in_valid_i/in_stall_o | volt_0_i .. volt_8_i (Q4.12)
// output   | out_valid_o/out_stall_i | torque_0_o .. torque_7_o (Q8.8)
// config   | APB psel/penable      | paddr, pwdata (64 bit), prdata
// An item in warmup is discarded without a stall. Other items stall the input while each of
// the eight channels is read, started in the shared 28-step divider, waited on and written;
// a channel whose divisor is zero skips the divider. The running phase adds an emit state;
// the last averaging item adds eight offset divisions (read, start, wait, write each).
// Reset clears phase and counters; channel memory needs no clearing.
// A finished result waits in the output registers while stall is high.
// Top level: sequencer, registers; uses otc_pkg, otc_ram, otc_div.
module optical_torque_calibrator_top
  import otc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [AddrBits-1:0] paddr,
  input  logic [63:0]         pwdata,
  output logic [63:0]         prdata,
  output logic                pready,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic signed [15:0]  volt_0_i,
  input  logic signed [15:0]  volt_1_i,
  input  logic signed [15:0]  volt_2_i,
  input  logic signed [15:0]  volt_3_i,
  input  logic signed [15:0]  volt_4_i,
  input  logic signed [15:0]  volt_5_i,
  input  logic signed [15:0]  volt_6_i,
  input  logic signed [15:0]  volt_7_i,
  input  logic signed [15:0]  volt_8_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic signed [15:0]  torque_0_o,
  output logic signed [15:0]  torque_1_o,
  output logic signed [15:0]  torque_2_o,
  output logic signed [15:0]  torque_3_o,
  output logic signed [15:0]  torque_4_o,
  output logic signed [15:0]  torque_5_o,
  output logic signed [15:0]  torque_6_o,
  output logic signed [15:0]  torque_7_o
);

  logic [63:0]          c1_lo_q, c1_hi_q, c2_lo_q, c2_hi_q;
  logic [CountBits-1:0] warm_q, avg_q;
  logic                 cfg_wr;
  reg_idx_e             cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_e'(paddr[5:3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_lo_q <= '0;
      c1_hi_q <= '0;
      c2_lo_q <= '0;
      c2_hi_q <= '0;
      warm_q  <= CountBits'(500);
      avg_q   <= CountBits'(1000);
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_C1_LO:   c1_lo_q <= pwdata;
        REG_C1_HI:   c1_hi_q <= pwdata;
        REG_C2_LO:   c2_lo_q <= pwdata;
        REG_C2_HI:   c2_hi_q <= pwdata;
        REG_WARMUP:  warm_q  <= pwdata[CountBits-1:0];
        REG_AVERAGE: avg_q   <= pwdata[CountBits-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_C1_LO:   prdata = c1_lo_q;
      REG_C1_HI:   prdata = c1_hi_q;
      REG_C2_LO:   prdata = c2_lo_q;
      REG_C2_HI:   prdata = c2_hi_q;
      REG_WARMUP:  prdata = 64'(warm_q);
      REG_AVERAGE: prdata = 64'(avg_q);
      default:     prdata = '0;
    endcase
  end

  // sequencer state
  state_e               state_q, state_d;
  phase_e               phase_q;
  logic [CountBits-1:0] count_q;
  logic [ChBits-1:0]    ch_q;
  logic                 zden_q;
  logic signed [15:0]   volt_q [Channels];
  logic signed [15:0]   work_q [Channels];
  logic signed [15:0]   out_q  [Channels];
  logic                 out_valid_q, out_valid_d;

  logic                 in_acc, discard, last_ch, avg_done;
  logic [CountBits-1:0] n_avg, count_inc;

  assign in_acc    = in_valid_i && !in_stall_o;
  assign in_stall_o = state_q != ST_IDLE;
  assign discard   = (phase_q == PH_WARMUP) && (count_q < warm_q);
  assign last_ch   = ch_q == ChBits'(Channels - 1);
  assign n_avg     = (avg_q == '0) ? CountBits'(1) : avg_q;
  assign count_inc = count_q + 1'b1;
  assign avg_done  = count_inc >= n_avg;

  // per-channel coefficients
  logic signed [15:0] c1, c2;
  logic [63:0]        c1_w, c2_w;
  always_comb begin
    c1_w = ch_q[2] ? c1_hi_q : c1_lo_q;
    c2_w = ch_q[2] ? c2_hi_q : c2_lo_q;
    c1   = c1_w[16*ch_q[1:0] +: 16];
    c2   = c2_w[16*ch_q[1:0] +: 16];
  end

  logic signed [16:0] den;
  logic [DvsBits-1:0] den_mag;
  logic [16:0]        c1_mag;
  assign den     = 17'(volt_q[ch_q]) + 17'(c2);
  assign den_mag = den[16] ? DvsBits'(-den) : DvsBits'(den);
  assign c1_mag  = c1[15] ? 17'(-17'(c1)) : 17'(c1);

  // memory and divider hookup
  entry_t              rd_entry, wr_entry;
  logic                mem_we, mem_re, div_start, div_done;
  logic [DivBits-1:0]  div_dividend;
  logic [DvsBits-1:0]  div_divisor;
  logic                div_neg;
  logic signed [15:0]  div_res, raw;
  logic signed [SumBits-1:0] sum_base, sum_sat, sum_mag_src;
  logic signed [SumBits:0]   sum_ext;
  logic signed [16:0]        tq_ext;
  logic signed [15:0]        tq_sat;

  otc_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (ch_q),
    .wdata_i (wr_entry),
    .re_i    (mem_re),
    .raddr_i (ch_q),
    .rdata_o (rd_entry)
  );

  otc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .neg_i      (div_neg),
    .done_o     (div_done),
    .result_o   (div_res)
  );

  assign raw = zden_q ? (c1[15] ? 16'sh8000 : 16'sh7fff) : div_res;

  // first averaging item starts from an empty sum
  assign sum_base = (count_q == '0) ? '0 : rd_entry.sum;
  assign sum_ext  = (SumBits+1)'(sum_base) + (SumBits+1)'(raw);
  always_comb begin
    if (sum_ext[SumBits] != sum_ext[SumBits-1]) begin
      sum_sat = sum_ext[SumBits] ? {1'b1, {(SumBits-1){1'b0}}} : {1'b0, {(SumBits-1){1'b1}}};
    end else begin
      sum_sat = sum_ext[SumBits-1:0];
    end
  end

  assign tq_ext = 17'(raw) + 17'(rd_entry.offset);
  always_comb begin
    if (tq_ext[16] != tq_ext[15]) begin
      tq_sat = tq_ext[16] ? 16'sh8000 : 16'sh7fff;
    end else begin
      tq_sat = tq_ext[15:0];
    end
  end

  assign sum_mag_src = rd_entry.sum;

  always_comb begin
    if (state_q == ST_OFS_START) begin
      div_dividend = sum_mag_src[SumBits-1] ? DivBits'(-sum_mag_src) : DivBits'(sum_mag_src);
      div_divisor  = DvsBits'(n_avg);
      div_neg      = sum_mag_src[SumBits-1];
    end else begin
      div_dividend = {DivBits'(c1_mag)} << 12;
      div_divisor  = den_mag;
      div_neg      = c1[15] ^ den[16];
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:      if (in_acc && !discard) state_d = ST_READ;
      ST_READ:      state_d = ST_START;
      ST_START:     state_d = (den == '0) ? ST_WRITE : ST_WAIT;
      ST_WAIT:      if (div_done) state_d = ST_WRITE;
      ST_WRITE: begin
        if (!last_ch) begin
          state_d = ST_READ;
        end else if (phase_q == PH_RUN) begin
          state_d = ST_EMIT;
        end else begin
          state_d = avg_done ? ST_OFS_READ : ST_IDLE;
        end
      end
      ST_OFS_READ:  state_d = ST_OFS_START;
      ST_OFS_START: state_d = ST_OFS_WAIT;
      ST_OFS_WAIT:  if (div_done) state_d = ST_OFS_WRITE;
      ST_OFS_WRITE: state_d = last_ch ? ST_IDLE : ST_OFS_READ;
      ST_EMIT:      if (!out_valid_q || !out_stall_i) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    div_start = 1'b0;
    wr_entry  = rd_entry;
    unique case (state_q)
      ST_READ, ST_OFS_READ: mem_re = 1'b1;
      ST_START:     div_start = den != '0;
      ST_OFS_START: div_start = 1'b1;
      ST_WRITE: begin
        mem_we       = phase_q == PH_AVERAGE;
        wr_entry.sum = sum_sat;
      end
      ST_OFS_WRITE: begin
        mem_we          = 1'b1;
        wr_entry.offset = div_res;
      end
      default: ;
    endcase
  end

  // result handoff: a new result may load when the output is empty or draining
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (state_q == ST_EMIT && (!out_valid_q || !out_stall_i)) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_WARMUP;
      count_q     <= '0;
      ch_q        <= '0;
      zden_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      unique case (state_q)
        ST_IDLE: begin
          ch_q <= '0;
          if (in_acc) begin
            if (discard) begin
              count_q <= count_inc;
            end else if (phase_q == PH_WARMUP) begin
              phase_q <= PH_AVERAGE;
              count_q <= '0;
            end
          end
        end
        ST_START: zden_q <= den == '0;
        ST_WRITE: begin
          ch_q <= ch_q + 1'b1;
          if (last_ch && phase_q == PH_AVERAGE) begin
            count_q <= avg_done ? '0 : count_inc;
          end
        end
        ST_OFS_WRITE: begin
          ch_q <= ch_q + 1'b1;
          if (last_ch) phase_q <= PH_RUN;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      volt_q[0] <= volt_0_i;
      volt_q[1] <= volt_1_i;
      volt_q[2] <= volt_3_i;
      volt_q[3] <= volt_4_i;
      volt_q[4] <= volt_5_i;
      volt_q[5] <= volt_6_i;
      volt_q[6] <= volt_7_i;
      volt_q[7] <= volt_8_i;
    end
    if (state_q == ST_WRITE) begin
      work_q[ch_q] <= tq_sat;
    end
    if (state_q == ST_EMIT && (!out_valid_q || !out_stall_i)) begin
      out_q <= work_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign torque_0_o  = out_q[0];
  assign torque_1_o  = out_q[1];
  assign torque_2_o  = out_q[2];
  assign torque_3_o  = out_q[3];
  assign torque_4_o  = out_q[4];
  assign torque_5_o  = out_q[5];
  assign torque_6_o  = out_q[6];
  assign torque_7_o  = out_q[7];

  logic unused_volt2;
  assign unused_volt2 = ^volt_2_i;

endmodule

// ----- design/otc_ram.sv -----
// Channel state memory: eight entries of offset and running sum.
// One write port, one read port, registered read data. Uses otc_pkg.
module otc_ram
  import otc_pkg::*;
(
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ChBits-1:0] waddr_i,
  input  entry_t            wdata_i,
  input  logic              re_i,
  input  logic [ChBits-1:0] raddr_i,
  output entry_t            rdata_o
);

  entry_t mem [Channels];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/otc_div.sv -----
// Restoring divider, one quotient bit per cycle, signed result saturated to 16 bits.
// Uses otc_pkg.
module otc_div
  import otc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [DivBits-1:0] dividend_i,
  input  logic [DvsBits-1:0] divisor_i,
  input  logic               neg_i,
  output logic               done_o,
  output logic signed [15:0] result_o
);

  localparam int unsigned CntBits = $clog2(DivBits);

  logic [DvsBits-1:0] rem_q, rem_d, dvs_q;
  logic [DivBits-1:0] quo_q, quo_d;
  logic [CntBits-1:0] cnt_q;
  logic               busy_q, done_q, neg_q;
  logic [DvsBits:0]   trial;
  logic               fits;

  assign trial = {rem_q, quo_q[DivBits-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    rem_d = fits ? DvsBits'(trial - {1'b0, dvs_q}) : trial[DvsBits-1:0];
    quo_d = {quo_q[DivBits-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntBits'(DivBits - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
      neg_q <= neg_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  always_comb begin
    if (neg_q) begin
      result_o = (quo_q > DivBits'(32768)) ? 16'sh8000 : 16'(-quo_q);
    end else begin
      result_o = (quo_q > DivBits'(32767)) ? 16'sh7fff : 16'(quo_q);
    end
  end

  assign done_o = done_q;

endmodule

// ----- design/otc_checker.sv -----
// Port-level checks for the optical torque calibrator, bound to the top level.
// Imports otc_pkg; no port uses its widths.
module otc_checker
  import otc_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               pready,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [15:0] torque_0_o,
  input logic signed [15:0] torque_7_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(torque_0_o) && $stable(torque_7_o))
    else $error("stalled result changed");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without work in progress");

endmodule

bind optical_torque_calibrator_top otc_checker u_otc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .pready      (pready),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .torque_0_o  (torque_0_o),
  .torque_7_o  (torque_7_o)
);
